FILE: design/pidt_pkg.sv
package pidt_pkg;

    localparam int FRAC_BITS  = 8;

    localparam int PITCH_W    = 17;
    localparam int ERR_W      = PITCH_W + 1;
    localparam int SUM_W      = 16;
    localparam int SUM_EXT_W  = ERR_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int CUT_W      = 17;
    localparam int DRIVE_W    = 32;
    localparam int P_KP_W     = GAIN_W + 1 + ERR_W;
    localparam int P_KI_W     = GAIN_W + 1 + SUM_W;
    localparam int P_KD_W     = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W      = P_KD_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_CUTOFF    = 3'd5;

    typedef struct packed {
        logic signed [PITCH_W-1:0] setpoint;
        logic [GAIN_W-1:0]         kp_gain;
        logic [GAIN_W-1:0]         ki_gain;
        logic [GAIN_W-1:0]         kd_gain;
        logic [LIM_W-1:0]          integral_limit;
        logic [CUT_W-1:0]          tilt_cutoff;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        setpoint:       17'sd0,
        kp_gain:        16'd11520,
        ki_gain:        16'd2560,
        kd_gain:        16'd3840,
        integral_limit: 15'd2048,
        tilt_cutoff:    17'd7680
    };

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
        logic                     cut;
    } front_t;

    typedef struct packed {
        logic signed [P_KP_W-1:0] p_kp;
        logic signed [P_KI_W-1:0] p_ki;
        logic signed [P_KD_W-1:0] p_kd;
        logic                     cut;
    } prod_t;

endpackage

FILE: design/pidt_cfg.sv
module pidt_cfg
    import pidt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETPOINT:       cfg_next.setpoint       = $signed(cfg_wdata[PITCH_W-1:0]);
                REG_KP_GAIN:        cfg_next.kp_gain        = cfg_wdata[GAIN_W-1:0];
                REG_KI_GAIN:        cfg_next.ki_gain        = cfg_wdata[GAIN_W-1:0];
                REG_KD_GAIN:        cfg_next.kd_gain        = cfg_wdata[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_wdata[LIM_W-1:0];
                REG_TILT_CUTOFF:    cfg_next.tilt_cutoff    = cfg_wdata[CUT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/pidt_front.sv
module pidt_front
    import pidt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [PITCH_W-1:0] pitch,
    output logic                      out_valid,
    input  logic                      out_ready,
    output front_t                    out_data
);

    logic                        valid_reg;
    front_t                      data_reg;
    front_t                      data_next;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [ERR_W-1:0]     prev_reg;

    logic signed [ERR_W-1:0]     err;
    logic signed [SUM_EXT_W-1:0] sum_raw;
    logic signed [SUM_EXT_W-1:0] lim_pos;
    logic signed [SUM_EXT_W-1:0] lim_neg;
    logic signed [SUM_EXT_W-1:0] sum_clamped;
    logic [ERR_W-1:0]            mag;
    logic                        accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        err     = {pitch[PITCH_W-1], pitch} - {cfg.setpoint[PITCH_W-1], cfg.setpoint};
        sum_raw = {{(SUM_EXT_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg}
                + {{(SUM_EXT_W-ERR_W){err[ERR_W-1]}}, err};
        lim_pos = $signed({{(SUM_EXT_W-LIM_W){1'b0}}, cfg.integral_limit});
        lim_neg = -lim_pos;
        if (sum_raw > lim_pos)
        begin
            sum_clamped = lim_pos;
        end
        else if (sum_raw < lim_neg)
        begin
            sum_clamped = lim_neg;
        end
        else
        begin
            sum_clamped = sum_raw;
        end
        mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

        data_next.err  = err;
        data_next.sum  = sum_clamped[SUM_W-1:0];
        data_next.diff = {err[ERR_W-1], err} - {prev_reg[ERR_W-1], prev_reg};
        data_next.cut  = mag > {{(ERR_W-CUT_W){1'b0}}, cfg.tilt_cutoff};
    end

    // advance the integrator and previous error once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sum_reg   <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (accept)
            begin
                sum_reg  <= data_next.sum;
                prev_reg <= data_next.err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: design/pidt_mul.sv
module pidt_mul
    import pidt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output prod_t  out_data
);

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;
    logic  accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        data_next.p_kp = $signed({1'b0, cfg.kp_gain}) * in_data.err;
        data_next.p_ki = $signed({1'b0, cfg.ki_gain}) * in_data.sum;
        data_next.p_kd = $signed({1'b0, cfg.kd_gain}) * in_data.diff;
        data_next.cut  = in_data.cut;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: design/pidt_out.sv
module pidt_out
    import pidt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  prod_t                     in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DRIVE_W-1:0] drive,
    output logic                      cut_off
);

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    logic                      valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic                      cut_reg;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   shifted;
    logic [ACC_W-DRIVE_W:0]    top_bits;
    logic                      accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        acc = {{(ACC_W-P_KP_W){in_data.p_kp[P_KP_W-1]}}, in_data.p_kp}
            + {{(ACC_W-P_KI_W){in_data.p_ki[P_KI_W-1]}}, in_data.p_ki}
            + {{(ACC_W-P_KD_W){in_data.p_kd[P_KD_W-1]}}, in_data.p_kd};
        shifted  = acc >>> FRAC_BITS;
        top_bits = shifted[ACC_W-1:DRIVE_W-1];
        if (in_data.cut)
        begin
            drive_next = '0;
        end
        else if ((top_bits == '0) || (top_bits == '1))
        begin
            drive_next = shifted[DRIVE_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            drive_next = DRIVE_MIN;
        end
        else
        begin
            drive_next = DRIVE_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg <= drive_next;
            cut_reg   <= in_data.cut;
        end
    end

    assign out_valid = valid_reg;
    assign drive     = drive_reg;
    assign cut_off   = cut_reg;

endmodule

FILE: design/pid_tilt_controller_unit.sv
// Tilt PID controller with integral clamp, one drive value for both motors.
// Configuration: cfg_we, cfg_index, cfg_wdata write one register per cycle
// (0 setpoint, 1 kp, 2 ki, 3 kd, 4 integral limit, 5 tilt cutoff); other
// indexes are dropped. Write only while no request is in flight.
// Input: one pitch sample per request on in_valid / in_ready.
// Output: drive and cut_off per request on out_valid / out_ready.
// Three register stages: error and integrator, the three gain products,
// then sum, shift, saturation and cutoff into the output register.
// A result is offered once it has passed the front, product and output
// registers; one request is taken every cycle while in_ready is high; the
// integrator loop closes within the first stage, so consecutive samples do
// not wait on each other.
// When the receiver stalls, stages fill one by one and in_ready drops only
// once all three hold a result; empty stages keep taking requests.
// Reset empties the pipeline, clears the integrator and previous error,
// and loads the default gains, limit and cutoff.
module pid_tilt_controller_unit
    import pidt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [PITCH_W-1:0] pitch,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DRIVE_W-1:0] drive,
    output logic                      cut_off
);

    cfg_t   cfg;
    logic   front_valid;
    logic   front_ready;
    front_t front_data;
    logic   mul_valid;
    logic   mul_ready;
    prod_t  mul_data;

    pidt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pitch     (pitch),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    pidt_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_data  (mul_data)
    );

    pidt_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_data   (mul_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .cut_off   (cut_off)
    );

    a_cut_zero_drive: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && cut_off) |-> (drive == '0)
    ) else $error("cut_off result carries nonzero drive");

    a_full_only_when_stalled: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && front_valid && mul_valid)
    ) else $error("input stalled while pipeline has room");

    a_empty_after_reset: assert property (
        @(posedge clk)
        !rst_n |=> (!out_valid && in_ready)
    ) else $error("pipeline not empty after reset");

endmodule
